@@ hw/rtl/pose_hold_matcher_macros.svh @@
// assertion macros for the pose hold matcher
// used by phm_ctrl and phm_datapath; compiled out when SYNTH is defined
`ifndef POSE_HOLD_MATCHER_MACROS_SVH
`define POSE_HOLD_MATCHER_MACROS_SVH
`ifndef SYNTH
// property checked at every rising edge outside reset
`define PHM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("phm assertion failed");
// condition in one cycle implies outcome in the next
`define PHM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("phm assertion failed");
`else
`define PHM_ASSERT(label, clk, rst_n, prop)
`define PHM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ hw/rtl/phm_pkg.sv @@
// shared types and constants of the pose hold matcher
// no dependencies; used by every other rtl file but the macros header
`default_nettype none
package phm_pkg;

	localparam int MAX_JOINTS    = 8;
	localparam int SLOT_W        = $clog2(MAX_JOINTS);
	localparam int USED_W        = $clog2(MAX_JOINTS + 1);
	localparam int ANGLE_W       = 14;
	localparam int TGT_W         = 16;
	localparam int TOL_W         = 12;
	localparam int HOLD_W        = 16;
	localparam int TIME_W        = 32;
	localparam int SUM_W         = 15;
	localparam int PROG_W        = 9;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;

	// one turn in 1/16 degree and the wrap point
	localparam int TURN_UNITS    = 5760;
	localparam int HALF_TURN     = 2880;
	// modulo reduction: offset makes the difference positive, four subtract steps
	localparam int RED_W         = 17;
	localparam int RED_STEPS     = 4;
	localparam int DIFF_OFFSET   = TURN_UNITS << (RED_STEPS - 1);
	localparam int MOD_W         = 13;
	localparam int SUM_MAX       = 32767;
	localparam int FULL_PROGRESS = 256;
	localparam int DIV_STEPS     = 8;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TGT_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JOINT_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS    = 3'd4;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 12'd64;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd500;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_RECOG = 2'd2,
		EV_END   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_REDUCE,
		ST_CHECK,
		ST_ELAPSED,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] tgt_first;
		logic [CFG_DATA_W-1:0] tgt_second;
		logic [3:0]            joint_count;
		logic [TOL_W-1:0]      tolerance;
		logic [HOLD_W-1:0]     hold_ms;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic diff;
		logic reduce;
		logic check;
		logic elapsed;
		logic div_step;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic need_div;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

@@ hw/rtl/phm_channels_if.sv @@
// valid/ready channel interfaces for joint items and frame results
// depends on phm_pkg for field widths
`default_nettype none
interface phm_in_if;
	logic                               valid;
	logic                               ready;
	logic [phm_pkg::SLOT_W-1:0]         slot;
	logic signed [phm_pkg::ANGLE_W-1:0] measured_angle;
	logic                               last_in_frame;
	logic [phm_pkg::TIME_W-1:0]         frame_time_ms;

	modport source (output valid, slot, measured_angle, last_in_frame, frame_time_ms,
		input ready);
	modport sink (input valid, slot, measured_angle, last_in_frame, frame_time_ms,
		output ready);
endinterface

interface phm_out_if;
	logic                            valid;
	logic                            ready;
	logic [phm_pkg::MAX_JOINTS-1:0]  aligned_mask;
	logic [phm_pkg::SUM_W-1:0]       total_angle_diff;
	logic [phm_pkg::PROG_W-1:0]      completion;
	logic [1:0]                      event_res;
	logic                            pose_active;

	modport source (output valid, aligned_mask, total_angle_diff, completion, event_res,
		pose_active, input ready);
	modport sink (input valid, aligned_mask, total_angle_diff, completion, event_res,
		pose_active, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/phm_ctrl.sv @@
// controller state machine of the pose hold matcher
// depends on phm_pkg and pose_hold_matcher_macros.svh; drives phm_datapath
`default_nettype none
`include "pose_hold_matcher_macros.svh"
module phm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire phm_pkg::status_t status,
	output phm_pkg::cmd_t         cmd
);

	phm_pkg::state_t               state_q;
	phm_pkg::state_t               state_d;
	logic [phm_pkg::DIV_CNT_W-1:0] cnt_q;

	// state register and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == phm_pkg::ST_ELAPSED) begin
				cnt_q <= '0;
			end else if (state_q == phm_pkg::ST_DIVIDE) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			phm_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = phm_pkg::ST_DIFF;
				end
			end
			phm_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = phm_pkg::ST_REDUCE;
			end
			phm_pkg::ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = phm_pkg::ST_CHECK;
			end
			phm_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = status.last ? phm_pkg::ST_ELAPSED : phm_pkg::ST_IDLE;
			end
			phm_pkg::ST_ELAPSED: begin
				cmd.elapsed = 1'b1;
				state_d     = status.need_div ? phm_pkg::ST_DIVIDE : phm_pkg::ST_EMIT;
			end
			phm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == phm_pkg::DIV_CNT_W'(phm_pkg::DIV_STEPS - 1)) begin
					state_d = phm_pkg::ST_EMIT;
				end
			end
			phm_pkg::ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = phm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = phm_pkg::ST_IDLE;
			end
		endcase
	end

	// a transfer reaches the tolerance check after the difference and reduction states
	`PHM_ASSERT(a_item_to_check, clk, arst_n, (state_q == phm_pkg::ST_IDLE && item_valid) |-> ##3 (state_q == phm_pkg::ST_CHECK))
	// a frame that needs the divider spends exactly its step count there
	`PHM_ASSERT(a_divide_len, clk, arst_n, (state_q == phm_pkg::ST_ELAPSED && status.need_div) |-> ##9 (state_q == phm_pkg::ST_EMIT))

endmodule
`default_nettype wire

@@ hw/rtl/phm_datapath.sv @@
// datapath of the pose hold matcher: angle check, frame state, hold timer,
// bit-serial progress divider and result register; depends on phm_pkg, phm_channels_if and the macros
`default_nettype none
`include "pose_hold_matcher_macros.svh"
module phm_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire phm_pkg::cfg_t                      cfg,
	input  wire phm_pkg::cmd_t                      cmd,
	output phm_pkg::status_t                        status,
	input  wire logic [phm_pkg::SLOT_W-1:0]         slot,
	input  wire logic signed [phm_pkg::ANGLE_W-1:0] measured_angle,
	input  wire logic                               last_in_frame,
	input  wire logic [phm_pkg::TIME_W-1:0]         frame_time_ms,
	phm_out_if.source                               results
);

	localparam int NJ = phm_pkg::MAX_JOINTS;

	// captured item
	logic [phm_pkg::SLOT_W-1:0]         slot_q;
	logic signed [phm_pkg::ANGLE_W-1:0] meas_q;
	logic                               last_q;
	logic [phm_pkg::TIME_W-1:0]         time_q;
	// working values
	logic                               in_use_q;
	logic [phm_pkg::RED_W-1:0]          diff_q;
	logic [phm_pkg::MOD_W-1:0]          mod_q;
	logic                               aligned_q;
	logic                               sat_q;
	logic                               gt_q;
	logic [NJ-1:0]                      mask_q;
	logic [phm_pkg::HOLD_W-1:0]         rem_q;
	logic [7:0]                         quo_q;
	// frame and hold state
	logic                               broken_q;
	logic [NJ-1:0]                      bits_q;
	logic [phm_pkg::SUM_W-1:0]          sum_q;
	logic                               started_q;
	logic [phm_pkg::TIME_W-1:0]         start_q;
	logic                               active_q;
	logic [phm_pkg::PROG_W-1:0]         prog_q;
	// result register
	logic                               out_valid_q;
	logic [NJ-1:0]                      out_mask_q;
	logic [phm_pkg::SUM_W-1:0]          out_sum_q;
	logic [phm_pkg::PROG_W-1:0]         out_prog_q;
	phm_pkg::event_t                    ev_q;

	// slots in use and their mask
	logic [phm_pkg::USED_W-1:0] used;
	logic [NJ-1:0]              used_mask;
	assign used = (cfg.joint_count > 4'(NJ)) ? phm_pkg::USED_W'(NJ)
		: phm_pkg::USED_W'(cfg.joint_count);
	assign used_mask = NJ'(((NJ+1)'(1) << used) - (NJ+1)'(1));

	// template angle of the captured slot, offset difference
	logic [2*phm_pkg::CFG_DATA_W-1:0]   targets;
	logic signed [phm_pkg::TGT_W-1:0]   tgt;
	logic signed [phm_pkg::RED_W:0]     diff_full;
	assign targets   = {cfg.tgt_second, cfg.tgt_first};
	assign tgt       = targets[{slot_q, 4'b0} +: phm_pkg::TGT_W];
	assign diff_full = (phm_pkg::RED_W+1)'(meas_q) - (phm_pkg::RED_W+1)'(tgt)
		+ (phm_pkg::RED_W+1)'(phm_pkg::DIFF_OFFSET);

	// modulo one turn by restoring subtraction of shifted turns
	logic [phm_pkg::RED_W-1:0] red;
	always_comb begin
		red = diff_q;
		for (int k = phm_pkg::RED_STEPS - 1; k >= 0; k--) begin
			if (red >= (phm_pkg::RED_W'(phm_pkg::TURN_UNITS) << k)) begin
				red = red - (phm_pkg::RED_W'(phm_pkg::TURN_UNITS) << k);
			end
		end
	end

	// wrapped absolute difference and saturating sum
	logic [phm_pkg::MOD_W-1:0]   wrap_mag;
	logic [phm_pkg::TOL_W-1:0]   abs_diff;
	logic [phm_pkg::SUM_W:0]     sum_ext;
	logic [phm_pkg::SUM_W-1:0]   sum_sat;
	assign wrap_mag = (mod_q >= phm_pkg::MOD_W'(phm_pkg::HALF_TURN))
		? phm_pkg::MOD_W'(phm_pkg::TURN_UNITS) - mod_q : mod_q;
	assign abs_diff = wrap_mag[phm_pkg::TOL_W-1:0];
	assign sum_ext  = (phm_pkg::SUM_W+1)'(sum_q) + (phm_pkg::SUM_W+1)'(abs_diff);
	assign sum_sat  = (sum_ext > (phm_pkg::SUM_W+1)'(phm_pkg::SUM_MAX))
		? phm_pkg::SUM_W'(phm_pkg::SUM_MAX) : sum_ext[phm_pkg::SUM_W-1:0];

	// frame end: alignment, elapsed time, divisor
	logic                        aligned_w;
	logic [phm_pkg::TIME_W-1:0]  elapsed;
	logic [phm_pkg::HOLD_W-1:0]  divisor;
	logic                        sat_w;
	assign aligned_w = !broken_q && ((bits_q & used_mask) == used_mask);
	assign elapsed   = time_q - start_q;
	assign divisor   = (cfg.hold_ms == '0) ? phm_pkg::HOLD_W'(1) : cfg.hold_ms;
	assign sat_w     = elapsed >= phm_pkg::TIME_W'(divisor);

	// one quotient bit per step
	logic [phm_pkg::HOLD_W:0] rem_shift;
	logic                     q_bit;
	assign rem_shift = {rem_q, 1'b0};
	assign q_bit     = rem_shift >= (phm_pkg::HOLD_W+1)'(divisor);

	// hold tracking at frame end
	logic                       started_d;
	logic                       active_d;
	logic [phm_pkg::PROG_W-1:0] prog_d;
	phm_pkg::event_t            ev_d;
	always_comb begin
		started_d = started_q;
		active_d  = active_q;
		prog_d    = prog_q;
		ev_d      = phm_pkg::EV_NONE;
		if (aligned_q) begin
			if (!active_q) begin
				if (!started_q) begin
					started_d = 1'b1;
					prog_d    = '0;
					ev_d      = phm_pkg::EV_START;
				end else begin
					prog_d = sat_q ? phm_pkg::PROG_W'(phm_pkg::FULL_PROGRESS)
						: phm_pkg::PROG_W'(quo_q);
					if (gt_q) begin
						started_d = 1'b0;
						active_d  = 1'b1;
						ev_d      = phm_pkg::EV_RECOG;
					end
				end
			end
		end else begin
			if (prog_q != '0) begin
				ev_d = phm_pkg::EV_END;
			end
			prog_d    = '0;
			started_d = 1'b0;
			active_d  = 1'b0;
		end
	end

	// item capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q <= slot;
			meas_q <= measured_angle;
			last_q <= last_in_frame;
			time_q <= frame_time_ms;
		end
		if (cmd.diff) begin
			in_use_q <= phm_pkg::USED_W'(slot_q) < used;
			diff_q   <= diff_full[phm_pkg::RED_W-1:0];
		end
		if (cmd.reduce) begin
			mod_q <= red[phm_pkg::MOD_W-1:0];
		end
		if (cmd.elapsed) begin
			aligned_q <= aligned_w;
			sat_q     <= sat_w;
			gt_q      <= elapsed > phm_pkg::TIME_W'(cfg.hold_ms);
			mask_q    <= bits_q & used_mask;
			rem_q     <= elapsed[phm_pkg::HOLD_W-1:0];
			quo_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? phm_pkg::HOLD_W'(rem_shift - (phm_pkg::HOLD_W+1)'(divisor))
				: rem_shift[phm_pkg::HOLD_W-1:0];
			quo_q <= {quo_q[6:0], q_bit};
		end
		if (cmd.emit) begin
			out_mask_q <= mask_q;
			out_sum_q  <= sum_q;
			out_prog_q <= prog_d;
		end
	end

	// frame, hold and result control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			broken_q    <= 1'b0;
			bits_q      <= '0;
			sum_q       <= '0;
			started_q   <= 1'b0;
			start_q     <= '0;
			active_q    <= 1'b0;
			prog_q      <= '0;
			out_valid_q <= 1'b0;
			ev_q        <= phm_pkg::EV_NONE;
		end else begin
			if (cmd.check && in_use_q) begin
				if (abs_diff > cfg.tolerance) begin
					broken_q <= 1'b1;
				end else begin
					bits_q[slot_q] <= 1'b1;
					sum_q          <= sum_sat;
				end
			end
			if (cmd.emit) begin
				broken_q    <= 1'b0;
				bits_q      <= '0;
				sum_q       <= '0;
				started_q   <= started_d;
				active_q    <= active_d;
				prog_q      <= prog_d;
				ev_q        <= ev_d;
				out_valid_q <= 1'b1;
				if (aligned_q && !active_q && !started_q) begin
					start_q <= time_q;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status and result channel
	assign status.last     = last_q;
	assign status.need_div = aligned_w && !active_q && started_q && !sat_w;
	assign status.out_busy = out_valid_q && !results.ready;

	assign results.valid            = out_valid_q;
	assign results.aligned_mask     = out_mask_q;
	assign results.total_angle_diff = out_sum_q;
	assign results.completion       = out_prog_q;
	assign results.event_res        = ev_q;
	assign results.pose_active      = active_q;

	// the hold timer never runs while the pose is active
	`PHM_ASSERT(a_timer_active_excl, clk, arst_n, !(active_q && started_q))
	// a recognized event always comes with the active flag
	`PHM_ASSERT(a_recog_active, clk, arst_n, (ev_q == phm_pkg::EV_RECOG) |-> active_q)
	// a start event leaves the timer running with no progress
	`PHM_ASSERT_NEXT(a_start_timer, clk, arst_n, cmd.emit && ev_d == phm_pkg::EV_START, started_q && prog_q == '0)

endmodule
`default_nettype wire

@@ hw/rtl/pose_hold_matcher.sv @@
// Pose hold matcher. Joint angles arrive one per transfer on items; each is
// wrapped against its template angle and checked against the tolerance. The
// transfer marked last_in_frame closes the frame and, once the result is
// taken from results, the frame mask, sum, hold progress, event and active
// flag appear as one result transfer. A joint transfer occupies the block
// through capture, difference, modulo reduction and check; a closing one
// adds the elapsed and result steps, and the divide steps while the hold
// timer runs below full progress, since the progress quotient comes from a
// bit-serial divider that yields one bit per cycle. A waiting result delays
// only the next frame close. Configuration writes on wr_en/wr_index/
// wr_data are taken at any time; writes to indexes past hold_ms are dropped.
// depends on phm_pkg, phm_channels_if, phm_ctrl and phm_datapath
`default_nettype none
module pose_hold_matcher (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [phm_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [phm_pkg::CFG_DATA_W-1:0]      wr_data,
	phm_in_if.sink                                   items,
	phm_out_if.source                                results
);

	phm_pkg::cfg_t    cfg_q;
	phm_pkg::cmd_t    cmd;
	phm_pkg::status_t status;
	logic             item_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tgt_first   <= '0;
			cfg_q.tgt_second  <= '0;
			cfg_q.joint_count <= '0;
			cfg_q.tolerance   <= phm_pkg::TOL_RESET;
			cfg_q.hold_ms     <= phm_pkg::HOLD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				phm_pkg::REG_TGT_FIRST:  cfg_q.tgt_first   <= wr_data;
				phm_pkg::REG_TGT_SECOND: cfg_q.tgt_second  <= wr_data;
				phm_pkg::REG_JOINT_CNT:  cfg_q.joint_count <= wr_data[3:0];
				phm_pkg::REG_TOLERANCE:  cfg_q.tolerance   <= wr_data[phm_pkg::TOL_W-1:0];
				phm_pkg::REG_HOLD_MS:    cfg_q.hold_ms     <= wr_data[phm_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign items.ready = item_ready;

	// sequencing
	phm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (items.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// arithmetic and state
	phm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.status         (status),
		.slot           (items.slot),
		.measured_angle (items.measured_angle),
		.last_in_frame  (items.last_in_frame),
		.frame_time_ms  (items.frame_time_ms),
		.results        (results)
	);

endmodule
`default_nettype wire

@@ dv/tb_pose_hold_matcher.sv @@
// self-checking testbench of pose_hold_matcher: a directed frame table, then random frames
// under a series of register settings, results checked by typed rows or a built-in predictor
// depends on phm_pkg, phm_channels_if and the pose_hold_matcher rtl
`default_nettype none
module tb_pose_hold_matcher;
	import phm_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 80;
	localparam int ANGLE_TOP     = (1 << (ANGLE_W - 1)) - 1;
	localparam int ANGLE_BOTTOM  = -(1 << (ANGLE_W - 1));

	// settings of the directed table from the row that reconfigures on
	localparam logic [CFG_DATA_W-1:0] DIR_TGT_LO = 64'hF4C0_8000_7FFF_0000;
	localparam logic [CFG_DATA_W-1:0] DIR_TGT_HI = 64'h1234_FF9C_0064_1680;
	localparam logic [3:0]            DIR_JOINTS = 4'd15;
	localparam logic [TOL_W-1:0]      DIR_TOL    = 12'd2880;
	localparam logic [HOLD_W-1:0]     DIR_HOLD   = 16'd0;

	typedef struct packed {
		logic [SLOT_W-1:0]         slot;
		logic signed [ANGLE_W-1:0] angle;
		logic                      last;
		logic [TIME_W-1:0]         stamp;
	} joint_t;

	typedef struct packed {
		logic [MAX_JOINTS-1:0] mask;
		logic [SUM_W-1:0]      diff;
		logic [PROG_W-1:0]     completion;
		event_t                ev;
		logic                  active;
	} frame_res_t;

	typedef struct packed {
		joint_t     item;
		logic       reconf;
		logic       typed;
		frame_res_t want;
	} table_row_t;

	typedef enum int {FR_WELL, FR_REPEAT, FR_MISSING, FR_BROKEN, FR_FLOOD, FR_NOISE} frame_kind_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic quiet;

	phm_in_if  items_ch ();
	phm_out_if results_ch ();

	pose_hold_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.items    (items_ch),
		.results  (results_ch)
	);

	// register mirror
	logic [CFG_DATA_W-1:0] tgt_lo     = '0;
	logic [CFG_DATA_W-1:0] tgt_hi     = '0;
	logic [3:0]            joints_cfg = '0;
	logic [TOL_W-1:0]      tol_cfg    = TOL_RESET;
	logic [HOLD_W-1:0]     hold_cfg   = HOLD_RESET;

	// frame and hold state of the predictor
	bit                    broken    = 1'b0;
	logic [MAX_JOINTS-1:0] seen_bits = '0;
	int unsigned           diff_acc  = 0;
	bit                    timing    = 1'b0;
	logic [TIME_W-1:0]     origin    = '0;
	bit                    active    = 1'b0;
	int unsigned           progress  = 0;

	frame_res_t  expected_frames[$];
	logic [TIME_W-1:0] clock_ms;
	int joints_sent     = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int settings_loaded = 0;
	int n_start = 0, n_recog = 0, n_end = 0, n_ceiling = 0;

	// directed frames; the first rows run on the reset settings and carry typed results
	table_row_t directed_rows [24] = '{
		'{'{3'd7, 14'sd8191, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd0, 14'h2000, 1'b1, 32'd100}, 1'b0, 1'b1, '{8'd0, 15'd0, 9'd0, EV_START, 1'b0}},
		'{'{3'd3, 14'sd0, 1'b1, 32'd300}, 1'b0, 1'b1, '{8'd0, 15'd0, 9'd102, EV_NONE, 1'b0}},
		'{'{3'd5, 14'sd1, 1'b1, 32'd601}, 1'b0, 1'b1, '{8'd0, 15'd0, 9'd256, EV_RECOG, 1'b1}},
		'{'{3'd6, -14'sd1, 1'b1, 32'hFFFF_FFFF}, 1'b0, 1'b1,
			'{8'd0, 15'd0, 9'd256, EV_NONE, 1'b1}},
		// large joint count, large tolerance, zero hold time; missing slots end the pose
		'{'{3'd0, 14'sd5760, 1'b0, 32'd123}, 1'b1, 1'b0, '0},
		'{'{3'd1, 14'h2000, 1'b1, 32'd1000}, 1'b0, 1'b0, '0},
		// full frame of extreme angles starts the hold
		'{'{3'd3, 14'sd8191, 1'b0, 32'hAAAA_5555}, 1'b0, 1'b0, '0},
		'{'{3'd0, 14'h2000, 1'b0, 32'h5555_AAAA}, 1'b0, 1'b0, '0},
		'{'{3'd7, 14'sd5760, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd1, -14'sd5760, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd6, 14'sd0, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd2, 14'sd2880, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd5, -14'sd2880, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd4, 14'sd1, 1'b1, 32'd7}, 1'b0, 1'b0, '0},
		// repeated slot, one millisecond later recognizes with zero hold time
		'{'{3'd7, -14'sd1, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd6, 14'sd4095, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd5, -14'sd4096, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd4, 14'sd2879, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd3, -14'sd2879, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd2, 14'sd5759, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd1, -14'sd5759, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd0, 14'sd8190, 1'b0, 32'd0}, 1'b0, 1'b0, '0},
		'{'{3'd0, 14'sd2881, 1'b1, 32'd8}, 1'b0, 1'b0, '0}
	};

	function automatic logic signed [TGT_W-1:0] template_of(input logic [SLOT_W-1:0] s);
		logic [CFG_DATA_W-1:0] word;
		word = s[2] ? tgt_hi : tgt_lo;
		return word[TGT_W*s[1:0] +: TGT_W];
	endfunction

	// absolute difference after wrapping into one half turn either way
	function automatic int unsigned wrapped_gap(input int m, input int t);
		int d;
		d = (m - t) % TURN_UNITS;
		if (d < 0) d += TURN_UNITS;
		if (d >= HALF_TURN) d -= TURN_UNITS;
		return (d < 0) ? -d : d;
	endfunction

	// advances the frame and hold state by one joint; returns 1 with the result at frame end
	function automatic bit absorb_joint(input joint_t j, output frame_res_t r);
		int unsigned used, gap;
		logic [MAX_JOINTS-1:0] used_mask;
		logic [TIME_W-1:0] elapsed;
		longint unsigned span, divisor, quot;
		bit aligned;
		r = '0;
		used_mask = '0;
		used = (joints_cfg > MAX_JOINTS) ? MAX_JOINTS : joints_cfg;
		for (int s = 0; s < used; s++) used_mask[s] = 1'b1;
		if (j.slot < used) begin
			gap = wrapped_gap(int'($signed(j.angle)), int'(template_of(j.slot)));
			if (gap > tol_cfg) begin
				broken = 1'b1;
			end else begin
				seen_bits[j.slot] = 1'b1;
				diff_acc = (diff_acc + gap > SUM_MAX) ? SUM_MAX : diff_acc + gap;
			end
		end
		if (!j.last) return 1'b0;

		aligned = !broken && ((seen_bits & used_mask) == used_mask);
		r.ev = EV_NONE;
		if (aligned) begin
			if (!active) begin
				if (!timing) begin
					timing = 1'b1;
					origin = j.stamp;
					progress = 0;
					r.ev = EV_START;
				end else begin
					elapsed = j.stamp - origin;
					span = 64'(elapsed);
					divisor = (hold_cfg == 0) ? 1 : hold_cfg;
					quot = span * FULL_PROGRESS / divisor;
					progress = (quot > FULL_PROGRESS) ? FULL_PROGRESS : 32'(quot);
					if (elapsed > hold_cfg) begin
						timing = 1'b0;
						active = 1'b1;
						r.ev = EV_RECOG;
					end
				end
			end
		end else begin
			if (progress > 0) r.ev = EV_END;
			progress = 0;
			timing = 1'b0;
			active = 1'b0;
		end
		r.mask = seen_bits & used_mask;
		r.diff = SUM_W'(diff_acc);
		r.completion = PROG_W'(progress);
		r.active = active;
		broken = 1'b0;
		seen_bits = '0;
		diff_acc = 0;
		return 1'b1;
	endfunction

	// measured angle whose wrapped difference to the template is delta, shifted by a turn at times
	function automatic logic signed [ANGLE_W-1:0] angle_near(input logic [SLOT_W-1:0] s,
		input int delta);
		int m;
		m = int'(template_of(s)) % TURN_UNITS + delta;
		if (m > ANGLE_TOP) m -= TURN_UNITS;
		if (m < ANGLE_BOTTOM) m += TURN_UNITS;
		if ($urandom_range(0, 3) == 0 && m + TURN_UNITS <= ANGLE_TOP) m += TURN_UNITS;
		else if ($urandom_range(0, 3) == 0 && m - TURN_UNITS >= ANGLE_BOTTOM) m -= TURN_UNITS;
		return ANGLE_W'(m);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s got %0d want %0d", results_checked, what, got,
				want);
	endtask

	// writes all five registers; narrow ones get random upper bits that must be dropped
	task automatic load_settings(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
		input logic [3:0] jc, input logic [TOL_W-1:0] tol, input logic [HOLD_W-1:0] hold);
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] junk;
		tgt_lo = lo;
		tgt_hi = hi;
		joints_cfg = jc;
		tol_cfg = tol;
		hold_cfg = hold;
		settings_loaded++;
		for (int r = 0; r < 5; r++) begin
			idx = CFG_IDX_W'(r);
			junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
			wr_en <= 1'b1;
			wr_index <= idx;
			case (idx)
				REG_TGT_FIRST: wr_data <= lo;
				REG_TGT_SECOND: wr_data <= hi;
				REG_JOINT_CNT: wr_data <= {junk[CFG_DATA_W-1:4], jc};
				REG_TOLERANCE: wr_data <= {junk[CFG_DATA_W-1:TOL_W], tol};
				default: wr_data <= {junk[CFG_DATA_W-1:HOLD_W], hold};
			endcase
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// one joint transfer; the expectation is queued when the transfer closes a frame
	task automatic send_joint(input joint_t j, input logic typed, input frame_res_t want);
		frame_res_t calc;
		if (!quiet && $urandom_range(0, 99) < 8) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.slot <= j.slot;
		items_ch.measured_angle <= j.angle;
		items_ch.last_in_frame <= j.last;
		items_ch.frame_time_ms <= j.stamp;
		do @(posedge clk); while (!items_ch.ready);
		joints_sent++;
		if (absorb_joint(j, calc)) begin
			if (typed) calc = want;
			expected_frames.insert(expected_frames.size(), calc);
			if (calc.ev == EV_START) n_start++;
			if (calc.ev == EV_RECOG) n_recog++;
			if (calc.ev == EV_END) n_end++;
			if (calc.diff == SUM_MAX) n_ceiling++;
		end
	endtask

	// sender pauses until every frame result is in, then lets the block settle
	task automatic wait_drained();
		items_ch.valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// builds one frame, mostly well formed, and sends it
	task automatic send_frame();
		joint_t frame_q[$];
		int order[$];
		frame_kind_t kind;
		joint_t j;
		int used, reach, delta, k, n;
		used = (joints_cfg > MAX_JOINTS) ? MAX_JOINTS : joints_cfg;
		reach = (tol_cfg > HALF_TURN) ? HALF_TURN : tol_cfg;
		j = '0;

		// frame shape: floods mostly where the tolerance lets every joint through
		k = $urandom_range(0, 99);
		if (tol_cfg >= HALF_TURN && k < 20) kind = FR_FLOOD;
		else begin
			k = $urandom_range(0, 99);
			if (k < 62) kind = FR_WELL;
			else if (k < 72) kind = FR_REPEAT;
			else if (k < 81) kind = FR_MISSING;
			else if (k < 90) kind = FR_BROKEN;
			else if (k < 96) kind = FR_NOISE;
			else kind = FR_FLOOD;
		end

		// shuffled slots in use
		for (int s = 0; s < used; s++) order.insert(order.size(), s);
		for (int s = used - 1; s > 0; s--) begin
			k = $urandom_range(0, s);
			n = order[s];
			order[s] = order[k];
			order[k] = n;
		end

		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 6)) begin
				j.slot = SLOT_W'($urandom);
				j.angle = ANGLE_W'($urandom);
				j.stamp = $urandom;
				frame_q.insert(frame_q.size(), j);
			end
		end else if (kind == FR_FLOOD) begin
			// many arrivals near half a turn off, often enough to reach the sum ceiling
			repeat ($urandom_range(12, 16)) begin
				j.slot = (used == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, used - 1));
				delta = $urandom_range(2700, HALF_TURN);
				if ($urandom_range(0, 1)) delta = -delta;
				j.angle = angle_near(j.slot, delta);
				j.stamp = $urandom;
				frame_q.insert(frame_q.size(), j);
			end
		end else begin
			foreach (order[i]) begin
				j.slot = SLOT_W'(order[i]);
				delta = $urandom_range(0, reach);
				if ($urandom_range(0, 1)) delta = -delta;
				j.angle = angle_near(j.slot, delta);
				j.stamp = $urandom;
				frame_q.insert(frame_q.size(), j);
			end
			case (kind)
				FR_REPEAT: if (used > 0) begin
					repeat ($urandom_range(1, 3)) begin
						j.slot = SLOT_W'(order[$urandom_range(0, used - 1)]);
						delta = $urandom_range(0, reach);
						if ($urandom_range(0, 1)) delta = -delta;
						j.angle = angle_near(j.slot, delta);
						frame_q.insert($urandom_range(0, frame_q.size()), j);
					end
				end
				FR_MISSING: if (frame_q.size() > 0) begin
					frame_q.delete($urandom_range(0, frame_q.size() - 1));
				end
				FR_BROKEN: if (frame_q.size() > 0 && reach < HALF_TURN) begin
					k = $urandom_range(0, frame_q.size() - 1);
					j = frame_q[k];
					delta = $urandom_range(reach + 1, HALF_TURN);
					if ($urandom_range(0, 1)) delta = -delta;
					j.angle = angle_near(j.slot, delta);
					frame_q[k] = j;
				end
				default: ;
			endcase
			// joints outside the template are ignored by the block
			if (used < MAX_JOINTS && ($urandom_range(0, 4) == 0 || frame_q.size() == 0)) begin
				j.slot = SLOT_W'($urandom_range(used, MAX_JOINTS - 1));
				j.angle = ANGLE_W'($urandom);
				frame_q.insert($urandom_range(0, frame_q.size()), j);
			end
		end
		if (frame_q.size() == 0) begin
			j.slot = SLOT_W'($urandom);
			j.angle = ANGLE_W'($urandom);
			frame_q.insert(frame_q.size(), j);
		end

		// frame time: mostly steps well inside the hold time, now and then a jump or a repeat
		k = $urandom_range(0, 99);
		if (k < 5) clock_ms = $urandom;
		else if (k >= 10) clock_ms += $urandom_range(0, hold_cfg / 2 + 2);
		j = frame_q[frame_q.size() - 1];
		j.last = 1'b1;
		j.stamp = clock_ms;
		frame_q[frame_q.size() - 1] = j;

		foreach (frame_q[i]) send_joint(frame_q[i], 1'b0, '0);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random stalls, field-by-field check against the oldest expectation
	initial begin : result_side
		frame_res_t got, want;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_ch.valid && results_ch.ready) begin
				got.mask = results_ch.aligned_mask;
				got.diff = results_ch.total_angle_diff;
				got.completion = results_ch.completion;
				got.ev = event_t'(results_ch.event_res);
				got.active = results_ch.pose_active;
				if (expected_frames.size() == 0) begin
					report_mismatch("result with nothing outstanding, mask", got.mask, 0);
				end else begin
					want = expected_frames.pop_front();
					if (got.mask !== want.mask)
						report_mismatch("aligned_mask", got.mask, want.mask);
					if (got.diff !== want.diff)
						report_mismatch("total_angle_diff", got.diff, want.diff);
					if (got.completion !== want.completion)
						report_mismatch("completion", got.completion, want.completion);
					if (got.ev !== want.ev)
						report_mismatch("event_res", got.ev, want.ev);
					if (got.active !== want.active)
						report_mismatch("pose_active", got.active, want.active);
				end
				results_checked++;
			end
			results_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);
		end
	end

	// stimulus: reset, directed table, random phases, drain and verdict
	initial begin : stimulus
		logic [CFG_DATA_W-1:0] lo, hi;
		logic [3:0] jc;
		logic [TOL_W-1:0] tol;
		logic [HOLD_W-1:0] hold;
		int phase_start;
		items_ch.valid <= 1'b0;
		items_ch.slot <= '0;
		items_ch.measured_angle <= '0;
		items_ch.last_in_frame <= 1'b0;
		items_ch.frame_time_ms <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		quiet <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].reconf) begin
				wait_drained();
				load_settings(DIR_TGT_LO, DIR_TGT_HI, DIR_JOINTS, DIR_TOL, DIR_HOLD);
			end
			send_joint(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		end
		clock_ms = $urandom;

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			jc = 4'($urandom_range(0, 15));
			tol = TOL_W'($urandom_range(16, 700));
			hold = HOLD_W'($urandom_range(1, 3000));
			// the first phases pin the extremes of the registers
			case (p)
				0: begin
					lo = {4{16'h8000}};
					hi = lo;
					jc = 4'd1;
					tol = '0;
					hold = 16'd1;
				end
				1: begin
					jc = 4'd8;
					tol = '1;
					hold = '1;
				end
				2: begin
					lo = {4{16'h7FFF}};
					hi = lo;
					jc = 4'd0;
					tol = TOL_W'(HALF_TURN);
					hold = '0;
				end
				3: jc = 4'd15;
				4: begin
					jc = 4'd4;
					tol = TOL_W'(HALF_TURN);
					hold = 16'd1;
				end
				default: ;
			endcase
			load_settings(lo, hi, jc, tol, hold);
			// one phase runs without any idling on either side
			quiet <= (p == 3);
			phase_start = joints_sent;
			while (joints_sent - phase_start < PHASE_ITEMS) send_frame();
		end

		wait_drained();
		$display("covered %0d joint transfers and %0d frame results under %0d register settings",
			joints_sent, results_checked, settings_loaded);
		$display("events seen: %0d starts, %0d recognitions, %0d ends; %0d sums at the ceiling",
			n_start, n_recog, n_end, n_ceiling);
		if (mismatches == 0) begin
			$display("** pose_hold_matcher: PASSED **");
		end else begin
			$display("** pose_hold_matcher: FAILED **");
		end
		$finish;
	end

	// watchdog, many times the slowest correct run
	initial begin
		#400000;
		$display("timeout with %0d frame results outstanding", expected_frames.size());
		$display("** pose_hold_matcher: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
